// ===== src/rwmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rwmf_pkg
// Types, codes and default sizes shared by the RGB window median filter.
// ----------------------------------------------------------------------------
package rwmf_pkg;

	localparam int DEF_MAX_RADIUS = 10;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam int RADIUS_CW = 4;
	localparam int WIDTH_CW  = 11;
	localparam int HEIGHT_CW = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [RADIUS_CW-1:0] RESET_RADIUS = 4'd1;
	localparam logic [WIDTH_CW-1:0]  RESET_WIDTH  = 11'd1024;
	localparam logic [HEIGHT_CW-1:0] RESET_HEIGHT = 13'd1024;

	localparam int HIST_DEPTH = 256;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RADIUS = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2
	} cfg_reg_e;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
		logic       frame_last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// index 0 red, 1 green, 2 blue
	typedef logic [2:0][7:0] rgb_t;

	typedef struct packed {
		logic sample_valid;
		logic scan_start;
	} med_ctrl_t;

	typedef struct packed {
		logic ready;
		logic done;
	} med_stat_t;

endpackage

// ===== src/rwmf_ram.sv =====
// ----------------------------------------------------------------------------
// rwmf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rwmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/rwmf_median.sv =====
// ----------------------------------------------------------------------------
// rwmf_median
// Per-channel histogram median: accumulate samples, then scan and clear.
// ----------------------------------------------------------------------------
module rwmf_median #(
	parameter int MAX_RADIUS = rwmf_pkg::DEF_MAX_RADIUS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rwmf_pkg::med_ctrl_t  ctrl,
	input  rwmf_pkg::rgb_t       sample,
	input  logic [$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1)-1:0] half,
	output rwmf_pkg::med_stat_t  stat,
	output rwmf_pkg::rgb_t       median
);
	import rwmf_pkg::*;

	localparam int SIDE  = 2*MAX_RADIUS+1;
	localparam int CNT_W = $clog2(SIDE*SIDE+1);
	localparam int HA_W  = $clog2(HIST_DEPTH);

	typedef enum logic [1:0] {M_CLEAR, M_IDLE, M_SCAN, M_LAST} mstate_t;

	mstate_t           state_q;
	logic [HA_W-1:0]   addr_q;
	logic              pend_q;
	logic              v_s1;
	rgb_t              addr_s1;
	logic              wv_q;
	rgb_t              waddr_q;
	logic [CNT_W-1:0]  wdata_q [3];
	logic              sv_q;
	logic [HA_W-1:0]   sa_q;
	logic [CNT_W-1:0]  acc_q [3];
	logic [2:0]        found_q;
	rgb_t              med_q;
	logic              done_q;

	logic              h_we;
	logic [HA_W-1:0]   h_waddr [3];
	logic [CNT_W-1:0]  h_wdata [3];
	logic [HA_W-1:0]   h_raddr [3];
	logic [CNT_W-1:0]  h_rdata [3];
	logic [CNT_W-1:0]  h_sum [3];

	for (genvar c = 0; c < 3; c++) begin : g_ch
		always_comb begin
			h_raddr[c] = (state_q == M_SCAN) ? addr_q : sample[c];
			h_sum[c]   = acc_q[c] + h_rdata[c];
			if (state_q == M_CLEAR || state_q == M_SCAN) begin
				h_waddr[c] = addr_q;
				h_wdata[c] = '0;
			end else begin
				h_waddr[c] = addr_s1[c];
				if (wv_q && waddr_q[c] == addr_s1[c]) begin
					h_wdata[c] = wdata_q[c] + 1'b1;
				end else begin
					h_wdata[c] = h_rdata[c] + 1'b1;
				end
			end
		end

		rwmf_ram #(
			.WIDTH(CNT_W),
			.DEPTH(HIST_DEPTH)
		) u_hist (
			.clk  (clk),
			.we   (h_we),
			.waddr(h_waddr[c]),
			.wdata(h_wdata[c]),
			.raddr(h_raddr[c]),
			.rdata(h_rdata[c])
		);
	end

	assign h_we = (state_q == M_CLEAR) || (state_q == M_SCAN) || v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_CLEAR;
			addr_q  <= '0;
			pend_q  <= 1'b0;
			v_s1    <= 1'b0;
			wv_q    <= 1'b0;
			sv_q    <= 1'b0;
			found_q <= '0;
			done_q  <= 1'b0;
		end else begin
			v_s1   <= ctrl.sample_valid && (state_q == M_IDLE);
			wv_q   <= v_s1;
			sv_q   <= (state_q == M_SCAN);
			done_q <= (state_q == M_LAST);
			if (sv_q) begin
				for (int c = 0; c < 3; c++) begin
					acc_q[c] <= h_sum[c];
					if (!found_q[c] && h_sum[c] > half) begin
						found_q[c] <= 1'b1;
						med_q[c]   <= sa_q;
					end
				end
			end
			unique case (state_q)
				M_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == HA_W'(HIST_DEPTH-1)) begin
						state_q <= M_IDLE;
					end
				end
				M_IDLE: begin
					if (pend_q || ctrl.scan_start) begin
						if (!ctrl.sample_valid && !v_s1) begin
							pend_q  <= 1'b0;
							addr_q  <= '0;
							found_q <= '0;
							med_q   <= '1;
							for (int c = 0; c < 3; c++) begin
								acc_q[c] <= '0;
							end
							state_q <= M_SCAN;
						end else begin
							pend_q <= 1'b1;
						end
					end
				end
				M_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == HA_W'(HIST_DEPTH-1)) begin
						state_q <= M_LAST;
					end
				end
				M_LAST: begin
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		sa_q    <= addr_q;
		addr_s1 <= sample;
		waddr_q <= addr_s1;
		for (int c = 0; c < 3; c++) begin
			wdata_q[c] <= h_wdata[c];
		end
	end

	assign stat.ready = (state_q != M_CLEAR);
	assign stat.done  = done_q;
	assign median     = med_q;

endmodule

// ===== src/rgb_window_median_filter.sv =====
// ----------------------------------------------------------------------------
// rgb_window_median_filter
// Streaming square-window median filter over RGBA pixels in raster order.
// ----------------------------------------------------------------------------
// Border or pass-through result: the center pixel passes S_RD, S_CTR and S_OUT
// into the output register. Interior result: one line store read per window
// pixel, then a 256-entry histogram scan. One item is in work at a time.
// After reset the 256 histogram entries are cleared; meanwhile no input is taken.
module rgb_window_median_filter #(
	parameter int MAX_RADIUS = rwmf_pkg::DEF_MAX_RADIUS,
	parameter int MAX_WIDTH  = rwmf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rwmf_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  rwmf_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output rwmf_pkg::out_item_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rwmf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rwmf_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rwmf_pkg::*;

	localparam int STORE_LINES = 2*MAX_RADIUS+1;
	localparam int DEPTH  = STORE_LINES*MAX_WIDTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SLOT_W = $clog2(STORE_LINES);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int LINE_W = $clog2(MAX_HEIGHT);
	localparam int WEFF_W = $clog2(MAX_WIDTH+1);
	localparam int HEFF_W = $clog2(MAX_HEIGHT+1);
	localparam int RAD_W  = $clog2(MAX_RADIUS+1);
	localparam int J_W    = $clog2(STORE_LINES);
	localparam int POS_W  = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
	localparam int CNT_W  = $clog2(STORE_LINES*STORE_LINES+1);

	typedef enum logic [2:0] {S_IDLE, S_RD, S_CTR, S_FILL, S_FLUSH, S_WAIT, S_OUT} state_t;

	state_t                  state_q;
	logic [RADIUS_CW-1:0]    cfg_radius_q;
	logic [WIDTH_CW-1:0]     cfg_width_q;
	logic [HEIGHT_CW-1:0]    cfg_height_q;
	logic [COL_W-1:0]        in_col_q;
	logic [LINE_W-1:0]       in_line_q;
	logic [SLOT_W-1:0]       in_slot_q;
	logic [POS_W-1:0]        in_pos_q;
	logic                    complete_q;
	logic [COL_W-1:0]        out_col_q;
	logic [LINE_W-1:0]       out_line_q;
	logic [SLOT_W-1:0]       out_slot_q;
	logic [COL_W-1:0]        em_col_q;
	logic [SLOT_W-1:0]       em_slot_q;
	logic                    interior_q;
	logic                    last_q;
	pixel_t                  center_q;
	pixel_t                  res_q;
	logic [SLOT_W-1:0]       win_slot_q;
	logic [COL_W-1:0]        win_col_q;
	logic [J_W-1:0]          win_i_q;
	logic [J_W-1:0]          win_j_q;
	logic                    fill_s1;
	logic                    out_valid_q;
	out_item_t               out_data_q;

	logic [RAD_W-1:0]        r_eff;
	logic [WEFF_W-1:0]       w_eff;
	logic [HEFF_W-1:0]       h_eff;
	logic [POS_W-1:0]        delay;
	logic [CNT_W-1:0]        side;
	logic [CNT_W-1:0]        half;
	logic [J_W-1:0]          two_r;
	logic                    in_acc;
	logic                    cfg_acc;
	logic                    st_we;
	logic [ADDR_W-1:0]       st_waddr;
	logic [ADDR_W-1:0]       st_raddr;
	pixel_t                  st_wdata;
	pixel_t                  st_rdata;
	logic                    emit;
	logic                    last_now;
	logic                    interior_now;
	med_ctrl_t               med_ctrl;
	med_stat_t               med_stat;
	rgb_t                    med_val;

	function automatic logic [ADDR_W-1:0] st_addr(input logic [SLOT_W-1:0] s,
			input logic [COL_W-1:0] c);
		return ADDR_W'(s) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
	endfunction

	always_comb begin
		if (int'(cfg_radius_q) > MAX_RADIUS) begin
			r_eff = RAD_W'(MAX_RADIUS);
		end else begin
			r_eff = RAD_W'(cfg_radius_q);
		end
		if (cfg_width_q == '0) begin
			w_eff = WEFF_W'(1);
		end else if (int'(cfg_width_q) > MAX_WIDTH) begin
			w_eff = WEFF_W'(MAX_WIDTH);
		end else begin
			w_eff = WEFF_W'(cfg_width_q);
		end
		if (cfg_height_q == '0) begin
			h_eff = HEFF_W'(1);
		end else if (int'(cfg_height_q) > MAX_HEIGHT) begin
			h_eff = HEFF_W'(MAX_HEIGHT);
		end else begin
			h_eff = HEFF_W'(cfg_height_q);
		end
	end

	assign delay = POS_W'(r_eff) * POS_W'(w_eff) + POS_W'(r_eff);
	assign side  = CNT_W'(2*int'(r_eff) + 1);
	assign half  = CNT_W'((side * side) >> 1);
	assign two_r = J_W'(2*int'(r_eff));

	assign in_ready  = (state_q == S_IDLE) && med_stat.ready && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;

	always_comb begin
		emit = 1'b0;
		if (in_data.opcode == OP_DRAIN) begin
			emit = complete_q;
		end else if (!complete_q) begin
			emit = (in_pos_q >= delay);
		end
	end

	assign last_now = (int'(out_line_q) + 1 == int'(h_eff)) &&
			(int'(out_col_q) + 1 == int'(w_eff));
	assign interior_now = (int'(out_line_q) >= int'(r_eff)) &&
			(int'(out_line_q) + int'(r_eff) < int'(h_eff)) &&
			(int'(out_col_q) >= int'(r_eff)) &&
			(int'(out_col_q) + int'(r_eff) < int'(w_eff));

	assign st_we    = in_acc && (in_data.opcode == OP_PIXEL) && !complete_q;
	assign st_waddr = st_addr(in_slot_q, in_col_q);
	assign st_wdata = '{alpha: in_data.alpha_in, blue: in_data.blue_in,
			green: in_data.green_in, red: in_data.red_in};
	assign st_raddr = (state_q == S_FILL) ? st_addr(win_slot_q, win_col_q)
			: st_addr(em_slot_q, em_col_q);

	rwmf_ram #(
		.WIDTH($bits(pixel_t)),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	assign med_ctrl.sample_valid = fill_s1;
	assign med_ctrl.scan_start   = (state_q == S_FLUSH);

	rwmf_median #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_median (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (med_ctrl),
		.sample({st_rdata.blue, st_rdata.green, st_rdata.red}),
		.half  (half),
		.stat  (med_stat),
		.median(med_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cfg_radius_q <= RESET_RADIUS;
			cfg_width_q  <= RESET_WIDTH;
			cfg_height_q <= RESET_HEIGHT;
			in_col_q     <= '0;
			in_line_q    <= '0;
			in_slot_q    <= '0;
			in_pos_q     <= '0;
			complete_q   <= 1'b0;
			out_col_q    <= '0;
			out_line_q   <= '0;
			out_slot_q   <= '0;
			fill_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			fill_s1 <= (state_q == S_FILL);
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_acc) begin
				unique case (cfg_index)
					CFG_RADIUS: cfg_radius_q <= cfg_data[RADIUS_CW-1:0];
					CFG_WIDTH:  cfg_width_q  <= cfg_data[WIDTH_CW-1:0];
					CFG_HEIGHT: cfg_height_q <= cfg_data[HEIGHT_CW-1:0];
					default: ;
				endcase
				if (cfg_index == CFG_RADIUS || cfg_index == CFG_WIDTH ||
						cfg_index == CFG_HEIGHT) begin
					in_col_q   <= '0;
					in_line_q  <= '0;
					in_slot_q  <= '0;
					in_pos_q   <= '0;
					complete_q <= 1'b0;
					out_col_q  <= '0;
					out_line_q <= '0;
					out_slot_q <= '0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (st_we) begin
							in_pos_q <= in_pos_q + 1'b1;
							if (int'(in_col_q) + 1 >= int'(w_eff)) begin
								in_col_q <= '0;
								if (int'(in_line_q) + 1 >= int'(h_eff)) begin
									in_line_q  <= '0;
									in_slot_q  <= '0;
									complete_q <= 1'b1;
								end else begin
									in_line_q <= in_line_q + 1'b1;
									in_slot_q <= (in_slot_q == SLOT_W'(STORE_LINES-1)) ?
											'0 : in_slot_q + 1'b1;
								end
							end else begin
								in_col_q <= in_col_q + 1'b1;
							end
						end
						if (emit) begin
							em_col_q   <= out_col_q;
							em_slot_q  <= out_slot_q;
							interior_q <= interior_now;
							last_q     <= last_now;
							state_q    <= S_RD;
							if (last_now) begin
								in_col_q   <= '0;
								in_line_q  <= '0;
								in_slot_q  <= '0;
								in_pos_q   <= '0;
								complete_q <= 1'b0;
								out_col_q  <= '0;
								out_line_q <= '0;
								out_slot_q <= '0;
							end else if (int'(out_col_q) + 1 >= int'(w_eff)) begin
								out_col_q  <= '0;
								out_line_q <= out_line_q + 1'b1;
								out_slot_q <= (out_slot_q == SLOT_W'(STORE_LINES-1)) ?
										'0 : out_slot_q + 1'b1;
							end else begin
								out_col_q <= out_col_q + 1'b1;
							end
						end
					end
				end
				S_RD: begin
					state_q <= S_CTR;
				end
				S_CTR: begin
					if (interior_q) begin
						state_q <= S_FILL;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_FILL: begin
					if (win_i_q == two_r && win_j_q == two_r) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (med_stat.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_CTR: begin
				center_q  <= st_rdata;
				res_q     <= st_rdata;
				win_i_q   <= '0;
				win_j_q   <= '0;
				win_col_q <= em_col_q - COL_W'(r_eff);
				if (int'(em_slot_q) >= int'(r_eff)) begin
					win_slot_q <= em_slot_q - SLOT_W'(r_eff);
				end else begin
					win_slot_q <= em_slot_q + SLOT_W'(STORE_LINES) - SLOT_W'(r_eff);
				end
			end
			S_FILL: begin
				if (win_j_q == two_r) begin
					win_j_q    <= '0;
					win_i_q    <= win_i_q + 1'b1;
					win_col_q  <= em_col_q - COL_W'(r_eff);
					win_slot_q <= (win_slot_q == SLOT_W'(STORE_LINES-1)) ?
							'0 : win_slot_q + 1'b1;
				end else begin
					win_j_q   <= win_j_q + 1'b1;
					win_col_q <= win_col_q + 1'b1;
				end
			end
			S_WAIT: begin
				if (med_stat.done) begin
					res_q <= '{alpha: center_q.alpha, blue: med_val[2],
							green: med_val[1], red: med_val[0]};
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_data_q <= '{red_out: res_q.red, green_out: res_q.green,
							blue_out: res_q.blue, alpha_out: res_q.alpha,
							frame_last: last_q};
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
